// ----- design/mefc_pkg.sv -----
// shared types and constants for the motion event frame capture block
// no dependencies
package mefc_pkg;

    // stored timestamp width
    localparam int TIME_W = 63;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // input request taken this cycle, apply run update
        logic start;    // load read cursors from the finished run
        logic issue;    // issue one store read toward the output
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic emit_due;   // a run is open and the offered frame is quiet
        logic can_issue;  // read stage free or moving on this cycle
        logic last_issue; // one read left for this event
    } t_dp_stat;

endpackage

// ----- design/mefc_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module mefc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mefc_ctrl.sv -----
// controller state machine for the motion event frame capture block
// depends on mefc_pkg
module mefc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output mefc_pkg::t_dp_cmd o_cmd,
    input  mefc_pkg::t_dp_stat i_stat
);

    typedef enum logic {
        IDLE,
        EMIT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_valid && !r_busy;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.start  = accept && i_stat.emit_due;
        o_cmd.issue  = (r_state == EMIT) && i_stat.can_issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                IDLE: begin
                    if (accept && i_stat.emit_due) begin
                        r_state <= EMIT;
                        r_busy  <= 1'b1;
                    end
                end
                EMIT: begin
                    if (i_stat.can_issue && i_stat.last_issue) begin
                        r_state <= IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_stall = r_busy;

endmodule

// ----- design/mefc_dp.sv -----
// datapath: run counters, start store, recent-frame ring and output pipeline
// depends on mefc_pkg and mefc_ram
module mefc_dp #(
    parameter int FIRST_DEPTH = 8,
    parameter int LAST_DEPTH  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_motion_seen,
    input  logic [mefc_pkg::TIME_W-1:0] i_frame_time,
    input  mefc_pkg::t_dp_cmd           i_cmd,
    output mefc_pkg::t_dp_stat          o_stat,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [mefc_pkg::TIME_W-1:0] o_clip_time,
    output logic                        o_from_tail,
    output logic                        o_last_of_clip
);

    localparam int HAW = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
    localparam int HCW = $clog2(FIRST_DEPTH + 1);
    localparam int TAW = (LAST_DEPTH > 1) ? $clog2(LAST_DEPTH) : 1;
    localparam int TCW = $clog2(LAST_DEPTH + 1);
    localparam int LW  = $clog2(FIRST_DEPTH + LAST_DEPTH + 1);

    // run state
    logic           r_in_motion;
    logic [HCW-1:0] r_head_fill;
    logic [TAW-1:0] r_wr_pos;
    logic [TCW-1:0] r_run_len;

    // read cursors
    logic [HAW-1:0] r_hidx;
    logic [HCW-1:0] r_hleft;
    logic [TAW-1:0] r_tptr;
    logic [LW-1:0]  r_left;

    // read stage and output register
    logic                        r_s1_vld;
    logic                        r_s1_tail;
    logic                        r_s1_last;
    logic                        r_out_vld;
    logic [mefc_pkg::TIME_W-1:0] r_out_time;
    logic                        r_out_tail;
    logic                        r_out_last;

    logic                        head_we;
    logic                        tail_we;
    logic                        head_sel;
    logic                        head_re;
    logic                        tail_re;
    logic                        adv1;
    logic [mefc_pkg::TIME_W-1:0] head_rdata;
    logic [mefc_pkg::TIME_W-1:0] tail_rdata;
    logic [TAW-1:0]              n_tptr_start;

    assign head_we  = i_cmd.accept && i_motion_seen && (r_head_fill < HCW'(FIRST_DEPTH));
    assign tail_we  = i_cmd.accept && i_motion_seen;
    assign head_sel = (r_hleft != '0);
    assign head_re  = i_cmd.issue && head_sel;
    assign tail_re  = i_cmd.issue && !head_sel;
    assign adv1     = r_s1_vld && (!r_out_vld || !i_stall);

    assign n_tptr_start = (r_wr_pos == '0) ? TAW'(LAST_DEPTH - 1) : r_wr_pos - 1'b1;

    assign o_stat.emit_due   = r_in_motion && !i_motion_seen;
    assign o_stat.can_issue  = !r_s1_vld || adv1;
    assign o_stat.last_issue = (r_left == LW'(1));

    mefc_ram #(
        .WIDTH(mefc_pkg::TIME_W),
        .DEPTH(FIRST_DEPTH)
    ) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (head_we),
        .i_waddr(r_head_fill[HAW-1:0]),
        .i_wdata(i_frame_time),
        .i_re   (head_re),
        .i_raddr(r_hidx),
        .o_rdata(head_rdata)
    );

    mefc_ram #(
        .WIDTH(mefc_pkg::TIME_W),
        .DEPTH(LAST_DEPTH)
    ) u_tail_ram (
        .i_clk  (i_clk),
        .i_we   (tail_we),
        .i_waddr(r_wr_pos),
        .i_wdata(i_frame_time),
        .i_re   (tail_re),
        .i_raddr(r_tptr),
        .o_rdata(tail_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_motion <= 1'b0;
            r_head_fill <= '0;
            r_wr_pos    <= '0;
            r_run_len   <= '0;
            r_left      <= '0;
            r_hleft     <= '0;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            // run bookkeeping
            if (i_cmd.accept) begin
                if (i_motion_seen) begin
                    r_in_motion <= 1'b1;
                    if (r_head_fill < HCW'(FIRST_DEPTH)) begin
                        r_head_fill <= r_head_fill + 1'b1;
                    end
                    if (r_wr_pos == TAW'(LAST_DEPTH - 1)) begin
                        r_wr_pos <= '0;
                    end else begin
                        r_wr_pos <= r_wr_pos + 1'b1;
                    end
                    if (r_run_len < TCW'(LAST_DEPTH)) begin
                        r_run_len <= r_run_len + 1'b1;
                    end
                end else begin
                    r_in_motion <= 1'b0;
                    r_head_fill <= '0;
                    r_run_len   <= '0;
                end
            end

            // read cursors: head entries oldest first, then ring newest first
            if (i_cmd.start) begin
                r_hleft <= r_head_fill;
                r_left  <= LW'(r_head_fill) + LW'(r_run_len);
            end else if (i_cmd.issue) begin
                r_left <= r_left - 1'b1;
                if (head_sel) begin
                    r_hleft <= r_hleft - 1'b1;
                end
            end

            // read stage
            if (i_cmd.issue) begin
                r_s1_vld <= 1'b1;
            end else if (adv1) begin
                r_s1_vld <= 1'b0;
            end

            // output register
            if (adv1) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hidx <= '0;
            r_tptr <= n_tptr_start;
        end else if (i_cmd.issue) begin
            if (head_sel) begin
                r_hidx <= r_hidx + 1'b1;
            end else if (r_tptr == '0) begin
                r_tptr <= TAW'(LAST_DEPTH - 1);
            end else begin
                r_tptr <= r_tptr - 1'b1;
            end
        end
        if (i_cmd.issue) begin
            r_s1_tail <= !head_sel;
            r_s1_last <= (r_left == LW'(1));
        end
        if (adv1) begin
            r_out_time <= r_s1_tail ? tail_rdata : head_rdata;
            r_out_tail <= r_s1_tail;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_clip_time    = r_out_time;
    assign o_from_tail    = r_out_tail;
    assign o_last_of_clip = r_out_last;

endmodule

// ----- design/motion_event_frame_capture.sv -----
// a frame that ends a run sends the controller to EMIT, which raises o_stall and issues store
// reads through a registered read stage into the output register; throughput: one frame per
// cycle while o_stall is low, one store read per cycle unless i_stall holds the output
// reset: i_rst_n, synchronous active low, closes any run and empties the output pipeline;
// store contents are left alone and are only read after being written in the same run
// top level: controller, datapath with start store and recent-frame ring
module motion_event_frame_capture #(
    parameter int FIRST_DEPTH = 8,
    parameter int LAST_DEPTH  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // frame requests
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_motion_seen,
    input  logic [mefc_pkg::TIME_W-1:0] i_frame_time,
    // clip timestamp requests
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mefc_pkg::TIME_W-1:0] o_clip_time,
    output logic                        o_from_tail,
    output logic                        o_last_of_clip
);

    mefc_pkg::t_dp_cmd  dp_cmd;
    mefc_pkg::t_dp_stat dp_stat;

    // controller: takes frame requests, sequences store reads on a run end
    mefc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_cmd  (dp_cmd),
        .i_stat (dp_stat)
    );

    // datapath: run counters, both stores, read stage and output register
    mefc_dp #(
        .FIRST_DEPTH(FIRST_DEPTH),
        .LAST_DEPTH (LAST_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_motion_seen (i_motion_seen),
        .i_frame_time  (i_frame_time),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_clip_time   (o_clip_time),
        .o_from_tail   (o_from_tail),
        .o_last_of_clip(o_last_of_clip)
    );

endmodule

// ----- design/mefc_checker.sv -----
// port-level checker for motion_event_frame_capture, bound to the top level
// depends on mefc_pkg
module mefc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_motion_seen,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [mefc_pkg::TIME_W-1:0] o_clip_time,
    input logic                        o_from_tail,
    input logic                        o_last_of_clip
);

    logic r_run;
    logic r_tail_open;

    // run open as seen from accepted frame requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_tail_open <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_run <= i_motion_seen;
            end
            if (o_valid && !i_stall) begin
                r_tail_open <= o_from_tail && !o_last_of_clip;
            end
        end
    end

    // output pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    // a quiet frame that ends a run makes the block busy while it emits
    a_run_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_motion_seen && r_run |=> o_stall)
        else $error("run end accepted without emission");

    // within an event, ring timestamps are never followed by start timestamps
    a_tail_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_tail_open |-> o_from_tail)
        else $error("start timestamp after ring timestamp in one event");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_clip_time)
            && $stable(o_from_tail) && $stable(o_last_of_clip))
        else $error("stalled result changed");

endmodule

bind motion_event_frame_capture mefc_checker u_mefc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_motion_seen (i_motion_seen),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_clip_time   (o_clip_time),
    .o_from_tail   (o_from_tail),
    .o_last_of_clip(o_last_of_clip)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for motion_event_frame_capture
// depends on mefc_pkg and the block's top level, nothing else
module tb_top;

    localparam int FIRST_DEPTH = 8;
    localparam int LAST_DEPTH  = 8;
    localparam int TIME_W      = mefc_pkg::TIME_W;
    // receiver hold-off long enough to back a full event up into the frame side
    localparam int LONG_HOLD   = 150;
    // frames that count toward each random phase
    localparam int PHASE_FRAMES = 80;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_motion_seen = 1'b0;
    logic [TIME_W-1:0] i_frame_time = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [TIME_W-1:0] o_clip_time;
    logic              o_from_tail;
    logic              o_last_of_clip;

    // percent of cycles each side idles, set per phase by the stimulus
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int unsigned hold_reqs = 0;

    typedef struct {
        logic [TIME_W-1:0] clip_time;
        logic              from_tail;
        logic              last_of_clip;
    } t_clip;

    // tracks runs the way the block does and keeps the clip timestamps still owed
    class t_clip_scoreboard;
        logic [TIME_W-1:0] start_times[FIRST_DEPTH];
        logic [TIME_W-1:0] recent_times[LAST_DEPTH];
        int unsigned       start_count;
        int unsigned       ring_pos;
        int unsigned       run_count;
        bit                run_open;
        t_clip             owed_clips[$];
        int unsigned       mismatches;

        function new();
            start_count = 0;
            ring_pos    = 0;
            run_count   = 0;
            run_open    = 1'b0;
            mismatches  = 0;
        endfunction

        // one accepted frame request
        function void note_frame(logic motion, logic [TIME_W-1:0] stamp);
            t_clip       c;
            int unsigned total;
            int unsigned k;
            int unsigned slot;
            if (run_open && !motion) begin
                total = start_count + run_count;
                k = 0;
                // start-of-run stamps in arrival order
                for (int i = 0; i < start_count; i++) begin
                    c.clip_time    = start_times[i];
                    c.from_tail    = 1'b0;
                    c.last_of_clip = (k == total - 1);
                    owed_clips     = {owed_clips, c};
                    k++;
                end
                // then the ring, newest first
                for (int i = 0; i < run_count; i++) begin
                    slot           = (ring_pos + LAST_DEPTH - 1 - i) % LAST_DEPTH;
                    c.clip_time    = recent_times[slot];
                    c.from_tail    = 1'b1;
                    c.last_of_clip = (k == total - 1);
                    owed_clips     = {owed_clips, c};
                    k++;
                end
            end
            if (motion) begin
                run_open = 1'b1;
                if (start_count < FIRST_DEPTH) begin
                    start_times[start_count] = stamp;
                    start_count++;
                end
                recent_times[ring_pos] = stamp;
                ring_pos = (ring_pos + 1) % LAST_DEPTH;
                if (run_count < LAST_DEPTH)
                    run_count++;
            end else begin
                run_open    = 1'b0;
                start_count = 0;
                run_count   = 0;
            end
        endfunction

        // one accepted clip request, compared with the oldest owed one
        function void check_clip(logic [TIME_W-1:0] stamp, logic tail, logic last);
            t_clip c;
            if (owed_clips.size() == 0) begin
                $display("%0t: unexpected clip request, actual time %h tail %b last %b",
                         $time, stamp, tail, last);
                mismatches++;
                return;
            end
            c = owed_clips.pop_front();
            if (stamp !== c.clip_time) begin
                $display("%0t: clip_time expected %h actual %h", $time, c.clip_time, stamp);
                mismatches++;
            end
            if (tail !== c.from_tail) begin
                $display("%0t: from_tail expected %b actual %b", $time, c.from_tail, tail);
                mismatches++;
            end
            if (last !== c.last_of_clip) begin
                $display("%0t: last_of_clip expected %b actual %b",
                         $time, c.last_of_clip, last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return owed_clips.size();
        endfunction
    endclass

    t_clip_scoreboard sb = new();

    motion_event_frame_capture #(
        .FIRST_DEPTH(FIRST_DEPTH),
        .LAST_DEPTH (LAST_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_motion_seen (i_motion_seen),
        .i_frame_time  (i_frame_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_clip_time   (o_clip_time),
        .o_from_tail   (o_from_tail),
        .o_last_of_clip(o_last_of_clip)
    );

    always #10 i_clk = ~i_clk;

    // offer one frame request and hold it until the block takes it
    task automatic send_frame(input logic motion, input logic [TIME_W-1:0] stamp);
        // sender gaps, decided without looking at the stall
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_motion_seen <= motion;
        i_frame_time  <= stamp;
        @(posedge i_clk);
        // values read here are the ones from before the edge
        while (o_stall)
            @(posedge i_clk);
        sb.note_frame(motion, stamp);
    endtask

    // stop offering and wait for every owed clip request
    task automatic drain_clips();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // random 63-bit stamp, now and then one of the extremes
    function automatic logic [TIME_W-1:0] rand_stamp();
        logic [TIME_W-1:0] s;
        case ($urandom_range(15))
            0: s = TIME_W'(1);
            1: s = '1;
            default: begin
                s = TIME_W'({$urandom, $urandom});
                if (s == '0)
                    s = TIME_W'(1);
            end
        endcase
        return s;
    endfunction

    // runs of random length, each closed by one or more quiet frames
    task automatic random_phase(input int unsigned budget);
        int unsigned counted;
        int unsigned run_len;
        int unsigned quiet_len;
        counted = 0;
        while (counted < budget) begin
            // mostly short runs, now and then one past both store depths
            if ($urandom_range(4) == 0)
                run_len = $urandom_range(10, 20);
            else
                run_len = $urandom_range(1, 9);
            for (int i = 0; i < run_len; i++)
                send_frame(1'b1, rand_stamp());
            // the first quiet frame closes the run, the rest are ignored
            quiet_len = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
            for (int i = 0; i < quiet_len; i++)
                send_frame(1'b0, rand_stamp());
            counted += run_len + 1;
        end
    endtask

    // receiver: checks every accepted clip request and drives the stall
    initial begin
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                sb.check_clip(o_clip_time, o_from_tail, o_last_of_clip);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // stimulus and end of run
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first phase idling: sender rarely, receiver mostly
        tx_idle_pct = 10;
        rx_idle_pct = 75;

        // quiet frame with no run open, largest stamp
        send_frame(1'b0, '1);
        // run of a single frame
        send_frame(1'b1, TIME_W'(1));
        send_frame(1'b0, TIME_W'(2));
        // zero and largest stamps inside a run
        send_frame(1'b1, TIME_W'(0));
        send_frame(1'b1, '1);
        send_frame(1'b0, TIME_W'(5));
        // long run: start store full, ring wraps, run count saturates
        for (int i = 0; i < 10; i++)
            send_frame(1'b1, rand_stamp());
        send_frame(1'b0, rand_stamp());
        // repeating 101 and 010 bit patterns, ring position carried over from the last run
        send_frame(1'b1, {21{3'b101}});
        send_frame(1'b1, {21{3'b010}});
        send_frame(1'b1, rand_stamp());
        send_frame(1'b0, rand_stamp());

        random_phase(PHASE_FRAMES);
        // sender pauses until every owed clip request is back
        drain_clips();

        // second phase idling: sender mostly, receiver rarely
        tx_idle_pct = 75;
        rx_idle_pct = 10;
        random_phase(PHASE_FRAMES);
        drain_clips();

        // third phase: no idling, opened by a long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs++;
        random_phase(PHASE_FRAMES);
        drain_clips();

        // catch any stray clip request after the last event
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- motion_event_frame_capture.f -----
design/mefc_pkg.sv
design/mefc_ram.sv
design/mefc_ctrl.sv
design/mefc_dp.sv
design/motion_event_frame_capture.sv
design/mefc_checker.sv
tb/tb_top.sv
